[hdl/nbit_field_unpacker_core_defines.svh]
// assertion macros used by the unpacker rtl
`ifndef NBIT_FIELD_UNPACKER_CORE_DEFINES_SVH
`define NBIT_FIELD_UNPACKER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property holds at every rising clock edge outside reset
`define NFU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition implies consequence in the following cycle
`define NFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define NFU_ASSERT(lbl, clk, rst_n, prop, msg)
`define NFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[hdl/nfu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package nfu_pkg;

  // fixed widths of the stream and the result
  localparam int unsigned BucketBits = 32;
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned WidthW     = 5;
  localparam int unsigned HeldW      = 6;
  localparam int unsigned ValueW     = 31;
  localparam int unsigned TakeW      = 3;

  // extraction limits and register reset
  localparam int unsigned MaxTake    = 4;
  localparam int unsigned MinWidth   = 2;
  localparam int unsigned WidthReset = 8;

  // default depth of the byte queue
  localparam int unsigned FifoDepth  = 2;

  // one queued byte request
  typedef struct packed {
    logic [ByteBits-1:0] data_byte;
    logic                start_of_stream;
  } nfu_item_t;

  // extraction engine state
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } nfu_state_e;

  // mask with the low n bits set, n up to the bucket width
  function automatic logic [BucketBits-1:0] low_bits(input logic [HeldW-1:0] n);
    logic [BucketBits-1:0] mask;
    if (n >= HeldW'(BucketBits)) begin
      mask = '1;
    end else begin
      mask = (BucketBits'(1) << n) - BucketBits'(1);
    end
    return mask;
  endfunction

endpackage

`default_nettype wire

[hdl/nbit_field_unpacker_core.sv]
// a byte is registered in the byte queue before the engine loads it, and each non-zero
// field is held pending until the next non-zero field or the end of its byte sends it out
// the engine takes up to four fields from each byte and loads the next byte as it ends the
// current one; a stalled output holds the engine when a second field waits; reset clears
// the byte queue, bucket, held, used and taken counters and the output, and sets width to 8
`timescale 1ns / 1ps
`default_nettype none

module nbit_field_unpacker_core import nfu_pkg::*; #(
  parameter int unsigned QueueDepth = FifoDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [WidthW-1:0]   field_width_i,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic [ByteBits-1:0] data_byte_i,
  input  wire logic                start_of_stream_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [ValueW-1:0]   field_value_o,
  output      logic                last_of_byte_o
);

  logic [WidthW-1:0] field_width_q;
  logic [WidthW-1:0] width_eff;
  logic              q_valid;
  nfu_item_t         q_item;
  logic              q_pop;

  // width register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_width_q <= WidthW'(WidthReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      field_width_q <= field_width_i;
    end
  end

  // widths below two act as two
  assign width_eff = (field_width_q < WidthW'(MinWidth)) ? WidthW'(MinWidth) : field_width_q;

  nfu_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .start_of_stream_i (start_of_stream_i),
    .q_valid_o         (q_valid),
    .q_item_o          (q_item),
    .q_pop_i           (q_pop)
  );

  nfu_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .width_i        (width_eff),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .field_value_o  (field_value_o),
    .last_of_byte_o (last_of_byte_o)
  );

endmodule

`default_nettype wire

[hdl/nfu_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module nfu_front import nfu_pkg::*; #(
  parameter int unsigned Depth = FifoDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic [ByteBits-1:0] data_byte_i,
  input  wire logic                start_of_stream_i,
  output      logic                q_valid_o,
  output      nfu_item_t           q_item_o,
  input  wire logic                q_pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  nfu_item_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push;
  logic                full;

  // queue status
  assign full       = (count_q == CntW'(Depth));
  assign in_stall_o = full;
  assign push       = in_valid_i && !full;
  assign q_valid_o  = (count_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !q_pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push && q_pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{data_byte: data_byte_i, start_of_stream: start_of_stream_i};
    end
  end

endmodule

`default_nettype wire

[hdl/nfu_back.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "nbit_field_unpacker_core_defines.svh"

module nfu_back import nfu_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [WidthW-1:0] width_i,
  input  wire logic              q_valid_i,
  input  wire nfu_item_t         q_item_i,
  output      logic              q_pop_o,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic [ValueW-1:0] field_value_o,
  output      logic              last_of_byte_o
);

  nfu_state_e              state_q, state_d;
  logic [BucketBits-1:0]   bucket_q, bucket_d;
  logic [HeldW-1:0]        held_q, held_d;
  logic [HeldW-1:0]        used_q, used_d;
  logic [TakeW-1:0]        taken_q, taken_d;
  logic                    pend_valid_q, pend_valid_d;
  logic [ValueW-1:0]       pend_val_q, pend_val_d;
  logic                    out_valid_q, out_valid_d;
  logic [ValueW-1:0]       out_val_q, out_val_d;
  logic                    out_last_q, out_last_d;

  logic [HeldW-1:0]        width_ext;
  logic                    can_extract;
  logic [HeldW-1:0]        shift;
  logic [HeldW-1:0]        held_rem;
  logic [BucketBits-1:0]   field;
  logic                    field_nz;
  logic                    out_free;
  logic                    byte_end;
  logic                    pad_en;
  logic                    pad;
  logic [BucketBits-1:0]   base_bucket;
  logic [HeldW-1:0]        base_held;
  logic [HeldW-1:0]        base_used;
  logic [BucketBits-1:0]   ld_bucket;
  logic [HeldW-1:0]        ld_held;
  logic [HeldW-1:0]        ld_used;
  logic [HeldW-1:0]        held_sum;

  // one field from the top of the held bits
  assign width_ext   = {1'b0, width_i};
  assign can_extract = (held_q >= width_ext) && (taken_q != TakeW'(MaxTake));
  assign shift       = held_q - width_ext;
  assign held_rem    = shift;
  assign field       = (bucket_q >> shift) & low_bits(width_ext);
  assign field_nz    = (field[ValueW-1:0] != '0);
  assign out_free    = !out_valid_q || !out_stall_i;

  // word padding check at the end of a byte
  assign pad = (({1'b0, used_q} + {2'b0, width_i}) > (HeldW + 1)'(BucketBits));

  // engine control
  always_comb begin
    state_d      = state_q;
    bucket_d     = bucket_q;
    held_d       = held_q;
    used_d       = used_q;
    taken_d      = taken_q;
    pend_valid_d = pend_valid_q;
    pend_val_d   = pend_val_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_val_d    = out_val_q;
    out_last_d   = out_last_q;
    q_pop_o      = 1'b0;
    byte_end     = 1'b0;
    pad_en       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        byte_end = 1'b1;
      end
      ST_RUN: begin
        if (can_extract) begin
          // a new non-zero field releases the pending one as not last
          if (!(field_nz && pend_valid_q) || out_free) begin
            held_d   = held_rem;
            used_d   = used_q + width_ext;
            bucket_d = bucket_q & low_bits(held_rem);
            taken_d  = taken_q + TakeW'(1);
            if (field_nz) begin
              pend_valid_d = 1'b1;
              pend_val_d   = field[ValueW-1:0];
              if (pend_valid_q) begin
                out_valid_d = 1'b1;
                out_val_d   = pend_val_q;
                out_last_d  = 1'b0;
              end
            end
          end
        end else if (!pend_valid_q || out_free) begin
          // byte done: flush the pending field marked last
          byte_end     = 1'b1;
          pad_en       = 1'b1;
          pend_valid_d = 1'b0;
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_val_d   = pend_val_q;
            out_last_d  = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // state after the finished byte
    if (pad_en && pad) begin
      base_bucket = '0;
      base_held   = '0;
      base_used   = '0;
    end else begin
      base_bucket = bucket_q;
      base_held   = held_q;
      base_used   = used_q;
    end

    // shift the next byte into the bucket
    if (q_item_i.start_of_stream) begin
      ld_bucket = '0;
      ld_held   = '0;
      ld_used   = '0;
    end else begin
      ld_bucket = base_bucket;
      ld_held   = base_held;
      ld_used   = base_used;
    end
    held_sum = ld_held + HeldW'(ByteBits);

    if (byte_end) begin
      if (q_valid_i) begin
        q_pop_o  = 1'b1;
        state_d  = ST_RUN;
        bucket_d = {ld_bucket[BucketBits-ByteBits-1:0], q_item_i.data_byte};
        held_d   = (held_sum > HeldW'(BucketBits)) ? HeldW'(BucketBits) : held_sum;
        used_d   = ld_used;
        taken_d  = '0;
      end else begin
        state_d  = ST_IDLE;
        bucket_d = base_bucket;
        held_d   = base_held;
        used_d   = base_used;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      bucket_q     <= '0;
      held_q       <= '0;
      used_q       <= '0;
      taken_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      bucket_q     <= bucket_d;
      held_q       <= held_d;
      used_q       <= used_d;
      taken_q      <= taken_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    pend_val_q <= pend_val_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign field_value_o  = out_val_q;
  assign last_of_byte_o = out_last_q;

  // checks
  `NFU_ASSERT(a_held_range, clk_i, rst_ni, held_q <= HeldW'(BucketBits), "bucket fill above 32")
  `NFU_ASSERT(a_take_limit, clk_i, rst_ni, taken_q <= TakeW'(MaxTake), "too many fields taken")
  `NFU_ASSERT(a_out_nonzero, clk_i, rst_ni, out_valid_q |-> (out_val_q != '0), "zero field sent")
  `NFU_ASSERT(a_idle_no_pend, clk_i, rst_ni, (state_q == ST_IDLE) |-> !pend_valid_q, "pending field left in idle")
  `NFU_ASSERT_NEXT(a_pop_runs, clk_i, rst_ni, q_pop_o, state_q == ST_RUN, "byte loaded but engine not running")

endmodule

`default_nettype wire
